// File: src/matrix_keypad_debouncer_macros.svh
// Assertion macros shared by the keypad debouncer RTL
`ifndef MATRIX_KEYPAD_DEBOUNCER_MACROS_SVH
`define MATRIX_KEYPAD_DEBOUNCER_MACROS_SVH

// same-cycle implication, checked outside reset
`define MKD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define MKD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/mkd_pkg.sv
// Types and constants for the matrix keypad debouncer
package mkd_pkg;

  localparam int NUM_ROWS     = 3;
  localparam int NUM_COLS     = 3;
  localparam int NUM_KEYS     = NUM_ROWS * NUM_COLS;
  localparam int ROW_W        = 2;
  localparam int COL_W        = 3;
  localparam int TIME_W       = 32;
  localparam int SW_W         = 4;
  localparam int KEY_W        = 9;
  localparam int DEB_W        = 16;
  localparam int APB_DATA_W   = 32;
  localparam int APB_ADDR_W   = 3;

  localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd10;

  // word index of the configuration registers (paddr[2])
  typedef enum logic {
    REG_DEBOUNCE = 1'b0
  } reg_index_t;

  typedef struct packed {
    logic [ROW_W-1:0]  row_index;
    logic [COL_W-1:0]  col_levels;
    logic [TIME_W-1:0] now_ms;
    logic [SW_W-1:0]   switch_levels;
  } sample_word_t;

  typedef struct packed {
    logic [KEY_W-1:0] key_matrix;
    logic [SW_W-1:0]  switch_state;
    logic             scan_complete;
  } report_word_t;

  // per-key lane control
  typedef struct packed {
    logic hit;
    logic pressed;
  } lane_ctl_t;

  // merge stage control
  typedef struct packed {
    logic accept;
    logic last;
  } merge_ctl_t;

endpackage

// File: src/matrix_keypad_debouncer.sv
// Top level: matrix keypad scanner with per-key debounce and switch block
//
//   channel  | handshake                      | word
//   ---------+--------------------------------+----------------------------
//   sample   | sample_valid / sample_stall    | sample (sample_word_t)
//   report   | report_valid / report_stall    | report (report_word_t)
//   config   | psel penable pwrite pready     | paddr, pwdata, prdata
//
// One word per cycle in while sample_stall is low, one word out; each result
// is registered in report, or in the skid register while report is stalled.
// All key lanes evaluate in parallel with 32-bit elapsed-time subtract/compare.
// Synchronous reset clears all key state, the switch register and the
// output buffer; debounce_ms returns to 10.
// A stalled report is held and the next one parks in a skid register;
// sample_stall rises only when both are full.
module matrix_keypad_debouncer
  import mkd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  output logic                  sample_stall,
  input  sample_word_t          sample,
  output logic                  report_valid,
  input  logic                  report_stall,
  output report_word_t          report,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

`include "matrix_keypad_debouncer_macros.svh"

  logic [DEB_W-1:0]    debounce_ms;
  logic                accept;
  logic [NUM_KEYS-1:0] keys_next;
  merge_ctl_t          mctl;
  reg_index_t          reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = reg_index_t'(paddr[2]);
  assign prdata  = (reg_sel == REG_DEBOUNCE)
                   ? {{(APB_DATA_W-DEB_W){1'b0}}, debounce_ms} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms <= DEBOUNCE_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel == REG_DEBOUNCE) begin
      debounce_ms <= pwdata[DEB_W-1:0];
    end
  end

  assign accept      = sample_valid && !sample_stall;
  assign mctl.accept = accept;
  assign mctl.last   = accept && (int'(sample.row_index) == NUM_ROWS - 1);

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    localparam int LROW = k / NUM_COLS;
    localparam int LCOL = k % NUM_COLS;
    lane_ctl_t lctl;

    assign lctl.hit = accept && (int'(sample.row_index) == LROW);
    if (LCOL < COL_W) begin : g_col
      assign lctl.pressed = ~sample.col_levels[LCOL];
    end else begin : g_nocol
      assign lctl.pressed = 1'b1;
    end

    mkd_key_lane u_lane (
      .clk         (clk),
      .rst         (rst),
      .ctl         (lctl),
      .now_ms      (sample.now_ms),
      .debounce_ms (debounce_ms),
      .key_next    (keys_next[k])
    );
  end

  mkd_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .ctl           (mctl),
    .keys_next     (keys_next),
    .switch_levels (sample.switch_levels),
    .report_stall  (report_stall),
    .report_valid  (report_valid),
    .report        (report),
    .sample_stall  (sample_stall)
  );

  `MKD_ASSERT_NOW(a_stall_only_when_full, sample_stall, report_valid,
    "input stalled while output register is empty")
  `MKD_ASSERT_NEXT(a_scan_flag, accept && !report_valid,
    report_valid && (report.scan_complete == $past(mctl.last)),
    "scan_complete does not follow the accepted row")
  `MKD_ASSERT_NOW(a_mid_rule, report_valid && (report.switch_state[1] != report.switch_state[3]),
    !report.switch_state[2], "mid set while up and down differ")

endmodule

// File: src/mkd_key_lane.sv
// One key: change stamp, last seen level and debounced level
module mkd_key_lane
  import mkd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  lane_ctl_t         ctl,
  input  logic [TIME_W-1:0] now_ms,
  input  logic [DEB_W-1:0]  debounce_ms,
  output logic              key_next
);

  logic              seen;
  logic [TIME_W-1:0] stamp;
  logic              debounced;

  logic              changed;
  logic [TIME_W-1:0] elapsed;
  logic              settled;

  assign changed = ctl.pressed != seen;
  assign elapsed = now_ms - stamp;
  assign settled = elapsed > {{(TIME_W-DEB_W){1'b0}}, debounce_ms};

  // a fresh change restarts the stamp and keeps the debounced level this time
  assign key_next = (ctl.hit && !changed && settled) ? ctl.pressed : debounced;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen      <= 1'b0;
      stamp     <= '0;
      debounced <= 1'b0;
    end else if (ctl.hit) begin
      if (changed) begin
        seen  <= ctl.pressed;
        stamp <= now_ms;
      end
      debounced <= key_next;
    end
  end

endmodule

// File: src/mkd_merge.sv
// Merges lane bits and switch pins into the report word; output skid buffer
module mkd_merge
  import mkd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  merge_ctl_t          ctl,
  input  logic [NUM_KEYS-1:0] keys_next,
  input  logic [SW_W-1:0]     switch_levels,
  input  logic                report_stall,
  output logic                report_valid,
  output report_word_t        report,
  output logic                sample_stall
);

  logic [SW_W-1:0] switch_reg;
  logic [SW_W-1:0] switch_next;
  logic [SW_W-1:0] switch_proc;
  report_word_t    word_next;
  report_word_t    skid;
  logic            skid_valid;
  logic            take;

  always_comb begin
    logic en, up, mid, dn;
    en  = switch_levels[0];
    up  = ~switch_levels[1];
    mid = ~switch_levels[2];
    dn  = ~switch_levels[3];
    if (up != dn) begin
      mid = 1'b0;
    end
    switch_proc = {dn, mid, up, en};
  end

  assign switch_next = (ctl.accept && ctl.last) ? switch_proc : switch_reg;

  always_comb begin
    word_next = '0;
    for (int i = 0; i < KEY_W; i++) begin
      if (i < NUM_KEYS) begin
        word_next.key_matrix[i] = keys_next[i];
      end
    end
    word_next.switch_state  = switch_next;
    word_next.scan_complete = ctl.last;
  end

  assign take         = report_valid && !report_stall;
  assign sample_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      switch_reg   <= '0;
      report_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else begin
      switch_reg <= switch_next;
      if (skid_valid) begin
        if (take) begin
          report     <= skid;
          skid_valid <= 1'b0;
        end
      end else if (ctl.accept) begin
        if (!report_valid || take) begin
          report       <= word_next;
          report_valid <= 1'b1;
        end else begin
          skid       <= word_next;
          skid_valid <= 1'b1;
        end
      end else if (take) begin
        report_valid <= 1'b0;
      end
    end
  end

endmodule
